/* hdl/posting_list_varint_encoder_assert.svh */
// Assertion macros for the posting list encoder checker.
`ifndef POSTING_LIST_VARINT_ENCODER_ASSERT_SVH
`define POSTING_LIST_VARINT_ENCODER_ASSERT_SVH

// Check a property outside reset.
`define PLVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define PLVE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/plve_pkg.sv */
// Types and constants shared by the posting list encoder modules.
package plve_pkg;

  localparam int unsigned IdW        = 32;
  localparam int unsigned GroupBits  = 7;
  localparam int unsigned BatchDepth = 4;
  localparam int unsigned CntW       = $clog2(BatchDepth);

  typedef enum logic {
    ModeArray = 1'b0,
    ModeRange = 1'b1
  } mode_e;

  localparam logic RegContainerMode = 1'b0;

  typedef struct packed {
    logic [IdW-1:0] doc_id;
    logic           last_id;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_list;
  } out_word_t;

  // Up to four values to send as varints, in order.
  typedef struct packed {
    logic [BatchDepth-1:0][IdW-1:0] vals;
    logic [CntW-1:0]                cnt_m1;
    logic                           last;
  } batch_t;

endpackage

/* hdl/plve_front.sv */
// Input register, list state and value selection for one id per cycle unless a batch waits on the serializer.
module plve_front
  import plve_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mode_e    mode_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_word_t in_data_i,
  output logic     bat_valid_o,
  output batch_t   bat_o,
  input  logic     bat_ready_i
);

  logic           in_vld_q;
  in_word_t       in_q;

  logic           started_q, started_d;
  logic           frs_q, frs_d;
  logic [IdW-1:0] prev_q, prev_d;
  logic [IdW-1:0] rs_q, rs_d;
  logic [IdW-1:0] re_q, re_d;
  logic [IdW-1:0] prs_q, prs_d;

  logic [IdW-1:0] id;
  logic           last;
  logic           brk;
  logic [IdW-1:0] rs_n, re_n, prs_mid;
  logic           frs_mid;
  logic [IdW-1:0] s1, l1, s2, l2;
  logic [CntW:0]  n;
  logic           advance;

  assign id   = in_q.doc_id;
  assign last = in_q.last_id;

  always_comb begin
    started_d  = started_q;
    frs_d      = frs_q;
    prev_d     = prev_q;
    rs_d       = rs_q;
    re_d       = re_q;
    prs_d      = prs_q;
    bat_o.vals = '0;
    bat_o.last = last;
    n          = '0;
    brk        = 1'b0;
    rs_n       = rs_q;
    re_n       = re_q;

    if (!started_q) begin
      rs_n = id;
      re_n = id;
    end else if (id == re_q + IdW'(1)) begin
      re_n = id;
    end else begin
      brk  = 1'b1;
      rs_n = id;
      re_n = id;
    end

    // Pending run, then the run left after this id.
    s1      = frs_q ? rs_q - prs_q : rs_q;
    l1      = re_q - rs_q + IdW'(1);
    prs_mid = brk ? rs_q : prs_q;
    frs_mid = brk | frs_q;
    s2      = frs_mid ? rs_n - prs_mid : rs_n;
    l2      = re_n - rs_n + IdW'(1);

    if (mode_i == ModeArray) begin
      bat_o.vals[0] = started_q ? id - prev_q : id;
      n             = (CntW+1)'(1);
      prev_d        = id;
      started_d     = 1'b1;
    end else begin
      started_d = 1'b1;
      rs_d      = rs_n;
      re_d      = re_n;
      prs_d     = prs_mid;
      frs_d     = frs_mid;
      if (brk) begin
        bat_o.vals[0] = s1;
        bat_o.vals[1] = l1;
        if (last) begin
          bat_o.vals[2] = s2;
          bat_o.vals[3] = l2;
          n             = (CntW+1)'(4);
        end else begin
          n = (CntW+1)'(2);
        end
      end else if (last) begin
        bat_o.vals[0] = s2;
        bat_o.vals[1] = l2;
        n             = (CntW+1)'(2);
      end
      if (last) begin
        prs_d = rs_n;
      end
    end

    if (last) begin
      started_d = 1'b0;
      frs_d     = 1'b0;
    end

    bat_o.cnt_m1 = CntW'(n - (CntW+1)'(1));
  end

  assign bat_valid_o  = in_vld_q && (n != '0);
  // Ids that only grow a run retire without touching the byte side.
  assign advance      = in_vld_q && ((n == '0) || bat_ready_i);
  assign in_ready_o   = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      started_q <= 1'b0;
      frs_q     <= 1'b0;
      prev_q    <= '0;
      rs_q      <= '0;
      re_q      <= '0;
      prs_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        started_q <= started_d;
        frs_q     <= frs_d;
        prev_q    <= prev_d;
        rs_q      <= rs_d;
        re_q      <= re_d;
        prs_q     <= prs_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

endmodule

/* hdl/plve_serial.sv */
// Varint serializer: turns a batch of values into LEB128 bytes.
module plve_serial
  import plve_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      bat_valid_i,
  input  batch_t    bat_i,
  output logic      bat_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic                           busy_q;
  logic [BatchDepth-2:0][IdW-1:0] vals_q;
  logic [CntW-1:0]                rem_q;
  logic                           last_q;
  logic [IdW-1:0]                 cur_q;
  logic                           out_vld_q;
  out_word_t                      out_q;

  logic [IdW-1:0] rest;
  logic           more;
  logic           emit;
  logic           bat_done;
  logic           load;

  assign rest        = cur_q >> GroupBits;
  assign more        = (rest != '0);
  assign emit        = busy_q && (!out_vld_q || out_ready_i);
  assign bat_done    = emit && !more && (rem_q == '0);
  assign bat_ready_o = !busy_q || bat_done;
  assign load        = bat_valid_i && bat_ready_o;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (load) begin
        busy_q <= 1'b1;
      end else if (bat_done) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte    <= {more, cur_q[GroupBits-1:0]};
      out_q.end_of_list <= !more && (rem_q == '0) && last_q;
    end
    if (load) begin
      cur_q  <= bat_i.vals[0];
      vals_q <= bat_i.vals[BatchDepth-1:1];
      rem_q  <= bat_i.cnt_m1;
      last_q <= bat_i.last;
    end else if (emit) begin
      if (more) begin
        cur_q <= rest;
      end else begin
        // Advance to the next value of the batch.
        cur_q <= vals_q[0];
        for (int i = 0; i < BatchDepth - 2; i++) begin
          vals_q[i] <= vals_q[i+1];
        end
        vals_q[BatchDepth-2] <= '0;
        rem_q                <= rem_q - CntW'(1);
      end
    end
  end

endmodule

/* hdl/posting_list_varint_encoder.sv */
// Posting list encoder top level: config register, id front end, byte serializer.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one 32-bit doc id
//   per word, with last_id set on the final id of a list. Output channel
//   (out_valid_o / out_ready_i / out_data_o) gives one encoded byte per word,
//   with end_of_list set on the final byte of the list.
//   container_mode (APB register 0, byte address 0) picks delta varint array
//   coding (0) or run range coding (1); write it only while the block is idle.
// Path: the first byte of an id passes the input register, then the batch
//   load into the serializer, then the output register.
// Throughput: one id per cycle while each id yields at most one byte and the
//   output is ready; the serializer emits one byte per cycle unless stalled, so
//   an id with more bytes holds the input. Range ids growing a run bypass it.
// Reset: clears the list state, the config register and all valid flags.
// Stall: while out_ready_i is low the output byte holds, the serializer
//   freezes, and the input side fills its register and drops ready once that id has bytes to send.
module posting_list_varint_encoder
  import plve_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style config port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  // Id words in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_data_i,
  // Byte words out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_data_o
);

  mode_e  mode_q;
  logic   bat_valid;
  logic   bat_ready;
  batch_t bat;
  logic   reg_idx;

  // Register index is the word address; index 1 decodes to nothing.
  assign reg_idx  = paddr_i[2];
  assign pready_o = 1'b1;

  always_comb begin
    unique case (reg_idx)
      RegContainerMode: prdata_o = {31'b0, mode_q};
      default:          prdata_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeArray;
    end else if (psel_i && penable_i && pwrite_i && pready_o &&
                 (reg_idx == RegContainerMode)) begin
      mode_q <= mode_e'(pwdata_i[0]);
    end
  end

  // Front end: holds the list state and picks the values each id sends.
  plve_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .bat_valid_o (bat_valid),
    .bat_o       (bat),
    .bat_ready_i (bat_ready)
  );

  // Serializer: one LEB128 byte per cycle into the output register while the output is ready.
  plve_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bat_valid_i (bat_valid),
    .bat_i       (bat),
    .bat_ready_o (bat_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hdl/plve_checker.sv */
// Port-level checker for the posting list encoder, bound to the top level.
`include "posting_list_varint_encoder_assert.svh"

module plve_checker
  import plve_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  `PLVE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "output word dropped")
  `PLVE_ASSERT(a_out_stable, out_valid_o && !out_ready_i |=> $stable(out_data_o), "payload moved")
  `PLVE_ASSERT(a_eol_final, out_valid_o && out_data_o.out_byte[7] |-> !out_data_o.end_of_list, "end of list on a continued byte")
  `PLVE_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "output valid in reset")

endmodule

bind posting_list_varint_encoder plve_checker u_plve_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/testbench.sv */
// Self-checking testbench for the posting list varint encoder: directed and random id lists.
module testbench;
  import plve_pkg::*;

  // Abort when no word moves on either channel for this many cycles.
  localparam int unsigned StallLimit    = 2000;
  // Quiet cycles after the last expected byte before touching the register
  // or ending the run. This covers range ids that are still in flight.
  localparam int unsigned SettleCycles  = 8;
  // Length of the long output hold-off used to fill the block.
  localparam int unsigned HoldOffCycles = 250;
  localparam int unsigned ReportMax     = 10;

  // Expected-byte model: mirrors the list and run state and keeps the bytes
  // still owed by the block in arrival order.
  class posting_scoreboard;
    mode_e       mode;
    bit          list_open;
    logic [31:0] prev_id;
    logic [31:0] run_first;
    logic [31:0] run_last;
    logic [31:0] prior_first;
    bit          run_sent;
    logic [31:0] value_q[$];
    out_word_t   byte_q[$];
    int unsigned errors;
    int unsigned ids_taken;
    int unsigned lists_closed;
    int unsigned bytes_matched;

    function new();
      mode          = ModeArray;
      list_open     = 1'b0;
      prev_id       = '0;
      run_first     = '0;
      run_last      = '0;
      prior_first   = '0;
      run_sent      = 1'b0;
      errors        = 0;
      ids_taken     = 0;
      lists_closed  = 0;
      bytes_matched = 0;
    endfunction

    function void fail(string what);
      errors++;
      if (errors <= ReportMax) begin
        $display("MISMATCH: %s", what);
      end
    endfunction

    // Queue the pending run as start (or start delta) and then its length.
    function void close_run();
      value_q.push_back(run_sent ? run_first - prior_first : run_first);
      value_q.push_back(run_last - run_first + 32'd1);
      prior_first = run_first;
      run_sent    = 1'b1;
    endfunction

    function void note_id(in_word_t w);
      logic [31:0] id;
      logic [31:0] v;
      out_word_t   b;
      int          n;
      id = w.doc_id;
      value_q.delete();
      ids_taken++;
      if (mode == ModeArray) begin
        value_q.push_back(list_open ? id - prev_id : id);
        prev_id   = id;
        list_open = 1'b1;
      end else begin
        if (!list_open) begin
          run_first = id;
          run_last  = id;
          list_open = 1'b1;
        end else if (id == run_last + 32'd1) begin
          run_last = id;
        end else begin
          close_run();
          run_first = id;
          run_last  = id;
        end
        if (w.last_id) begin
          close_run();
        end
      end
      // Split every value into 7-bit groups, low group first.
      n = value_q.size();
      for (int i = 0; i < n; i++) begin
        v = value_q[i];
        do begin
          b.out_byte = {1'b0, v[6:0]};
          v = v >> GroupBits;
          if (v != 0) begin
            b.out_byte[7] = 1'b1;
          end
          b.end_of_list = w.last_id && (i == n - 1) && (v == 0);
          byte_q.push_back(b);
        end while (v != 0);
      end
      if (w.last_id) begin
        list_open = 1'b0;
        run_sent  = 1'b0;
        lists_closed++;
      end
    endfunction

    function void check_byte(out_word_t got);
      out_word_t want;
      if (byte_q.size() == 0) begin
        fail($sformatf("byte %02h eol %0b with none expected", got.out_byte, got.end_of_list));
      end else begin
        want = byte_q.pop_front();
        if (got != want) begin
          fail($sformatf("byte %02h eol %0b, expected byte %02h eol %0b",
                         got.out_byte, got.end_of_list, want.out_byte, want.end_of_list));
        end else begin
          bytes_matched++;
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;
  logic        in_valid_i;
  logic        in_ready_o;
  in_word_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_word_t   out_data_o;

  posting_scoreboard sb = new();

  int unsigned tx_idle_pct;   // chance the sender idles before a word
  int unsigned rx_stall_pct;  // chance the receiver drops ready in a cycle
  int unsigned hold_left;     // cycles left in a forced receiver hold-off
  int unsigned quiet_cycles;  // cycles since the last word on either side

  posting_list_varint_encoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel_i),
    .penable_i  (penable_i),
    .pwrite_i   (pwrite_i),
    .paddr_i    (paddr_i),
    .pwdata_i   (pwdata_i),
    .prdata_o   (prdata_o),
    .pready_o   (pready_o),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: honor a pending hold-off first, otherwise stall at random.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Monitor: record every accepted id, check every accepted byte, and
  // count cycles in which nothing moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_id(in_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_byte(out_data_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Watchdog: a hung block or a missing byte ends the run here.
  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("watchdog: %0d cycles without a word, %0d bytes still owed",
             quiet_cycles, sb.byte_q.size());
    $display("testbench: done, errors");
    $finish;
  end

  // Offer one id; idle at random first, then hold valid until accepted.
  // Return at the falling edge after the handshake.
  task automatic send_id(input logic [31:0] id, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {id, last};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed byte, then let in-flight ids retire.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.byte_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write container_mode through APB on an idle block, then read it back.
  task automatic set_mode(input mode_e m);
    settle();
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= {RegContainerMode, 2'b00};
    pwdata_i  <= 32'(m);
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    sb.mode = m;
    @(negedge clk_i);
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    if (prdata_o != 32'(m)) begin
      sb.fail($sformatf("container_mode reads %08h, expected %08h", prdata_o, 32'(m)));
    end
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // Random lists: ascending ids with runs, gaps, jumps, repeats and
  // descents mixed in. Lists always end with last_id so state resets.
  task automatic run_lists(input int unsigned budget, input mode_e m);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [31:0] id;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      id  = ($urandom_range(1) == 0) ? $urandom() : $urandom_range(200);
      for (int unsigned k = 0; k < len; k++) begin
        send_id(id, k == len - 1);
        sent++;
        pick = $urandom_range(99);
        if (pick < ((m == ModeRange) ? 60 : 30)) begin
          id = id + 32'd1;
        end else if (pick < 80) begin
          id = id + $urandom_range(2, 300);
        end else if (pick < 90) begin
          id = id + $urandom();
        end else if (pick >= 95) begin
          id = id - $urandom_range(1, 50);
        end
        // otherwise repeat the same id
      end
    end
  endtask

  initial begin
    int unsigned tx_mix [4];
    int unsigned rx_mix [4];
    tx_mix = '{0, 55, 0, 30};
    rx_mix = '{0, 0, 55, 30};

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel_i       = 1'b0;
    penable_i    = 1'b0;
    pwrite_i     = 1'b0;
    paddr_i      = '0;
    pwdata_i     = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 0;
    quiet_cycles = 0;

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Array coding: zero, widest value, group-size boundaries, repeat, descent.
    set_mode(ModeArray);
    send_id(32'h0000_0000, 1'b1);
    send_id(32'hFFFF_FFFF, 1'b0);
    send_id(32'h0000_007E, 1'b0);
    send_id(32'h0000_00FE, 1'b0);
    send_id(32'h0000_40FD, 1'b0);
    send_id(32'h0000_80FD, 1'b0);
    send_id(32'h0000_80FD, 1'b0);
    send_id(32'h0000_0010, 1'b1);

    // Range coding: run wrapping past the top, descending and repeated ids,
    // then a one-id list at the top of the range.
    set_mode(ModeRange);
    send_id(32'hFFFF_FFFE, 1'b0);
    send_id(32'hFFFF_FFFF, 1'b0);
    send_id(32'h0000_0000, 1'b0);
    send_id(32'h0000_0001, 1'b0);
    send_id(32'h0000_0007, 1'b0);
    send_id(32'h0000_0003, 1'b0);
    send_id(32'h0000_0003, 1'b0);
    send_id(32'hF000_0000, 1'b1);
    send_id(32'hFFFF_FFFF, 1'b1);

    // Switch modes in the middle of a list: array coding picks up stale state.
    send_id(32'd100, 1'b0);
    send_id(32'd101, 1'b0);
    set_mode(ModeArray);
    send_id(32'h0000_0055, 1'b1);

    // Random lists under each flow-control mix, both modes.
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_mix[p];
      rx_stall_pct = rx_mix[p];
      set_mode(ModeArray);
      run_lists(50, ModeArray);
      set_mode(ModeRange);
      run_lists(50, ModeRange);
    end

    // Hold the output off for a long stretch while ids keep coming, so the
    // block fills up and drops input ready.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_mode(ModeArray);
    hold_left = HoldOffCycles;
    run_lists(40, ModeArray);

    settle();
    $display("summary: %0d ids in %0d lists, %0d bytes matched, %0d mismatches",
             sb.ids_taken, sb.lists_closed, sb.bytes_matched, sb.errors);
    $display("summary: array and range coding, run wrap, mid-list mode switch, "
             , "four flow-control mixes and a long output hold-off");
    if (sb.errors == 0 && sb.byte_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* posting_list_varint_encoder.f */
+incdir+hdl
hdl/plve_pkg.sv
hdl/plve_front.sv
hdl/plve_serial.sv
hdl/posting_list_varint_encoder.sv
hdl/plve_checker.sv
tb/testbench.sv
